// File: hw/rtl/rsd_pkg.sv
// Shared types, sizes and a helper function for the signed restoring divider.
package rsd_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int FIELD_W    = 64;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dividend;
    logic signed [FIELD_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quotient;
    logic signed [FIELD_W-1:0] remainder;
    logic                      divide_by_zero;
  } out_t;

  // State carried from cell to cell along the divider chain.
  typedef struct packed {
    word_t num;     // dividend magnitude, next bit to use sits at the top
    word_t den;     // divisor magnitude
    word_t rem;     // partial remainder
    word_t quo;     // quotient bits gathered so far
    logic  neg_q;
    logic  neg_r;
    logic  dbz;
  } stage_t;

  function automatic word_t negate(word_t v);
    return word_t'(~v + word_t'(1));
  endfunction

endpackage

// File: hw/rtl/rsd_prep.sv
// Entry stage: finds operand magnitudes and signs and registers them.
module rsd_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rsd_pkg::stage_t out_stage
);
  import rsd_pkg::*;

  logic   valid_r;
  stage_t stage_r;
  stage_t stage_nxt;
  word_t  a;
  word_t  b;
  logic   neg_a;
  logic   neg_b;

  always_comb begin
    a     = in_data.dividend[DATA_WIDTH-1:0];
    b     = in_data.divisor[DATA_WIDTH-1:0];
    neg_a = a[DATA_WIDTH-1];
    neg_b = b[DATA_WIDTH-1];
    stage_nxt.num   = neg_a ? negate(a) : a;
    stage_nxt.den   = neg_b ? negate(b) : b;
    stage_nxt.rem   = '0;
    stage_nxt.quo   = '0;
    stage_nxt.neg_q = neg_a ^ neg_b;
    stage_nxt.neg_r = neg_a;
    stage_nxt.dbz   = (b == '0);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// File: hw/rtl/rsd_cell.sv
// One divider cell: shifts in a dividend bit and subtracts the divisor if it fits.
module rsd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsd_pkg::stage_t in_stage,
  output logic            out_valid,
  input  logic            out_ready,
  output rsd_pkg::stage_t out_stage
);
  import rsd_pkg::*;

  logic                valid_r;
  stage_t              stage_r;
  stage_t              stage_nxt;
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH:0] diff;
  logic                fits;

  always_comb begin
    trial = {in_stage.rem, in_stage.num[DATA_WIDTH-1]};
    diff  = trial - {1'b0, in_stage.den};
    fits  = !diff[DATA_WIDTH];
    stage_nxt     = in_stage;
    stage_nxt.num = {in_stage.num[DATA_WIDTH-2:0], 1'b0};
    stage_nxt.rem = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    stage_nxt.quo = {in_stage.quo[DATA_WIDTH-2:0], fits};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// File: hw/rtl/rsd_post.sv
// Exit stage: applies result signs, handles a zero divisor, holds the output register.
module rsd_post (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsd_pkg::stage_t in_stage,
  output logic            out_valid,
  input  logic            out_ready,
  output rsd_pkg::out_t   out_data
);
  import rsd_pkg::*;

  logic  valid_r;
  out_t  data_r;
  out_t  data_nxt;
  word_t q;
  word_t r;

  always_comb begin
    q = in_stage.neg_q ? negate(in_stage.quo) : in_stage.quo;
    r = in_stage.neg_r ? negate(in_stage.rem) : in_stage.rem;
    if (in_stage.dbz) begin
      q = '0;
      r = '0;
    end
    data_nxt.quotient       = FIELD_W'($signed(q));
    data_nxt.remainder      = FIELD_W'($signed(r));
    data_nxt.divide_by_zero = in_stage.dbz;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: hw/rtl/restoring_signed_divider.sv
// Signed restoring divider built as a chain of one-bit divider cells.
// Order: entry stage, then each cell in turn, then output register; each holds one transaction.
// Throughput: one transaction per cycle while out_ready is high.
// Each stage's ready passes back to the previous one, so empty stages fill even while a result waits.
// Reset (rst_n low, synchronous) drops every transaction in flight; payload registers are not reset.
module restoring_signed_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsd_pkg::out_t out_data
);
  import rsd_pkg::*;

  logic   chain_valid [0:DATA_WIDTH];
  logic   chain_ready [0:DATA_WIDTH];
  stage_t chain_data  [0:DATA_WIDTH];

  rsd_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_stage (chain_data[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    rsd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_stage  (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_stage (chain_data[k+1])
    );
  end

  rsd_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[DATA_WIDTH]),
    .in_ready  (chain_ready[DATA_WIDTH]),
    .in_stage  (chain_data[DATA_WIDTH]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> chain_valid[0])
    else $error("accepted transaction did not enter the entry stage");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_valid[DATA_WIDTH] && !chain_data[DATA_WIDTH].dbz) |->
      (chain_data[DATA_WIDTH].rem < chain_data[DATA_WIDTH].den))
    else $error("final partial remainder not below divisor magnitude");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_by_zero) |->
      (out_data.quotient == '0 && out_data.remainder == '0))
    else $error("zero divisor result is not zero");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
